// ===== rtl/mcstb_pkg.sv =====
`timescale 1ns / 1ps
package mcstb_pkg;

  // Command codes carried in the op field
  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_START_ONCE = 3'd1,
    OP_START_AUTO = 3'd2,
    OP_STOP       = 3'd3,
    OP_CHECK      = 3'd4,
    OP_DELAY      = 3'd5,
    OP_ELAPSED    = 3'd6
  } mcstb_op_e;

  // Tick divider period and shortest delay length
  localparam logic [3:0]  TICK_DIVIDE = 4'd10;
  localparam logic [31:0] MIN_DELAY   = 32'd2;

  // Command item
  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  timer_id;
    logic [31:0] duration;
    logic [31:0] start_time;
  } mcstb_cmd_t;

  // Response item
  typedef struct packed {
    logic        expired;
    logic        delay_done;
    logic [31:0] run_time;
    logic [31:0] elapsed;
    logic        ten_tick_pulse;
  } mcstb_rsp_t;

  // One timer entry as held in the timer memory
  typedef struct packed {
    logic [31:0] remaining;
    logic [31:0] reload;
    logic        flag;
    logic        auto_mode;
  } mcstb_entry_t;

  // Requests to the global tick unit
  typedef struct packed {
    logic        tick;
    logic        delay_load;
    logic [31:0] duration;
  } mcstb_sys_cmd_t;

  // Global tick unit status
  typedef struct packed {
    logic        delay_done;
    logic [31:0] run_time;
    logic        pulse;
  } mcstb_sys_stat_t;

endpackage

// ===== rtl/mcstb_mem.sv =====
`timescale 1ns / 1ps
module mcstb_mem
  import mcstb_pkg::*;
#(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rd_en_i,
  input  logic [AW-1:0]      raddr_i,
  output mcstb_entry_t       rdata_o,
  input  logic               wr_en_i,
  input  logic [AW-1:0]      waddr_i,
  input  mcstb_entry_t       wdata_i
);

  mcstb_entry_t mem_q [DEPTH];
  logic [DEPTH-1:0] valid_q;
  mcstb_entry_t rdata_q;

  // Write the entry array
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Mark written entries; unwritten ones read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  // Register the read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= valid_q[raddr_i] ? mem_q[raddr_i] : '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mcstb_sys.sv =====
`timescale 1ns / 1ps
module mcstb_sys
  import mcstb_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mcstb_sys_cmd_t  cmd_i,
  output mcstb_sys_stat_t stat_o
);

  logic [31:0] delay_q;
  logic        timeout_q;
  logic [31:0] runtime_q;
  logic [3:0]  div_q;
  logic        pulse_q;

  // Advance delay, runtime and divider on a tick; load the delay on request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q   <= '0;
      timeout_q <= 1'b0;
      runtime_q <= '0;
      div_q     <= '0;
      pulse_q   <= 1'b0;
    end else if (cmd_i.tick) begin
      if (delay_q != '0) begin
        delay_q <= delay_q - 32'd1;
        if (delay_q == 32'd1) begin
          timeout_q <= 1'b1;
        end
      end
      runtime_q <= runtime_q + 32'd1;
      if (div_q == TICK_DIVIDE - 4'd1) begin
        div_q   <= '0;
        pulse_q <= 1'b1;
      end else begin
        div_q   <= div_q + 4'd1;
        pulse_q <= 1'b0;
      end
    end else if (cmd_i.delay_load && (cmd_i.duration != '0)) begin
      delay_q   <= (cmd_i.duration == 32'd1) ? MIN_DELAY : cmd_i.duration;
      timeout_q <= 1'b0;
    end
  end

  assign stat_o.delay_done = timeout_q;
  assign stat_o.run_time   = runtime_q;
  assign stat_o.pulse      = pulse_q;

endmodule

// ===== rtl/multi_channel_soft_timer_bank_core.sv =====
`timescale 1ns / 1ps
// Bank of NUM_TIMERS soft timers kept in one timer memory with a registered read port.
// An item is taken when start is high and busy is low; its response shows on rsp_o for
// exactly one cycle with rsp_valid_o high, and the receiver cannot hold it off, so it
// must take every response in that cycle. A tick sweeps the timer memory one entry a
// cycle, reading the next entry while writing back the one before, and the response is
// registered in the cycle of the last write-back; start, stop and check on a timer are one
// read in ST_ENT_RD and one write-back in ST_FINISH; delay, elapsed and the unused code go
// straight to ST_FINISH. A new item can be taken in the cycle its predecessor's response is shown.
module multi_channel_soft_timer_bank_core
  import mcstb_pkg::*;
#(
  parameter int NUM_TIMERS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  mcstb_cmd_t cmd_i,
  output logic       rsp_valid_o,
  output mcstb_rsp_t rsp_o
);

  localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW = $clog2(NUM_TIMERS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_ENT_RD,
    ST_FINISH
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]   cnt_m1;
  logic            ent_wb_q, ent_wb_d;
  mcstb_cmd_t      req_q;
  mcstb_rsp_t      rsp_q, rsp_d;
  logic            rsp_valid_q, rsp_valid_d;
  logic            accept;
  logic            id_ok;
  mcstb_op_e       acc_op, req_op;

  logic            rd_en, wr_en;
  logic [AW-1:0]   raddr, waddr;
  mcstb_entry_t    rdata, wdata;
  logic            ent_exp;
  logic            finish;

  mcstb_sys_cmd_t  sys_cmd;
  mcstb_sys_stat_t sys_stat;

  assign accept = start && !busy;
  assign acc_op = mcstb_op_e'(cmd_i.op);
  assign req_op = mcstb_op_e'(req_q.op);
  assign id_ok  = {1'b0, cmd_i.timer_id} < 9'(NUM_TIMERS);
  assign cnt_m1 = cnt_q - CW'(1);

  // Hand tick and delay commands to the global unit at acceptance
  assign sys_cmd.tick       = accept && (acc_op == OP_TICK);
  assign sys_cmd.delay_load = accept && (acc_op == OP_DELAY);
  assign sys_cmd.duration   = cmd_i.duration;

  mcstb_sys u_sys (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (sys_cmd),
    .stat_o (sys_stat)
  );

  mcstb_mem #(
    .DEPTH (NUM_TIMERS),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata),
    .wr_en_i (wr_en),
    .waddr_i (waddr),
    .wdata_i (wdata)
  );

  // Drive memory addresses from the sequencer
  always_comb begin
    rd_en = 1'b0;
    raddr = req_q.timer_id[AW-1:0];
    wr_en = 1'b0;
    waddr = req_q.timer_id[AW-1:0];
    if (state_q == ST_SWEEP) begin
      rd_en = (cnt_q != CW'(NUM_TIMERS));
      raddr = cnt_q[AW-1:0];
      wr_en = (cnt_q != '0);
      waddr = cnt_m1[AW-1:0];
    end else if (state_q == ST_ENT_RD) begin
      rd_en = 1'b1;
    end else if (ent_wb_q) begin
      wr_en = 1'b1;
    end
  end

  // Modify the entry read back: decrement on a tick, else apply the command
  always_comb begin
    wdata   = rdata;
    ent_exp = 1'b0;
    case (req_op)
      OP_TICK: begin
        if (rdata.remaining != '0) begin
          wdata.remaining = rdata.remaining - 32'd1;
          if (rdata.remaining == 32'd1) begin
            wdata.flag = 1'b1;
            if (rdata.auto_mode) begin
              wdata.remaining = rdata.reload;
            end
          end
        end
      end
      OP_START_ONCE, OP_START_AUTO: begin
        wdata.remaining = req_q.duration;
        wdata.reload    = req_q.duration;
        wdata.flag      = 1'b0;
        wdata.auto_mode = (req_op == OP_START_AUTO);
      end
      OP_STOP: begin
        wdata.remaining = '0;
        wdata.flag      = 1'b0;
      end
      OP_CHECK: begin
        ent_exp    = rdata.flag;
        wdata.flag = 1'b0;
      end
      default: begin
        wdata = rdata;
      end
    endcase
  end

  // Sequence the item through the memory
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ent_wb_d = 1'b0;
    finish   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cnt_d = '0;
          if (acc_op == OP_TICK) begin
            state_d = ST_SWEEP;
          end else if (id_ok && ((acc_op == OP_START_ONCE) || (acc_op == OP_START_AUTO) ||
                                 (acc_op == OP_STOP) || (acc_op == OP_CHECK))) begin
            state_d = ST_ENT_RD;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_SWEEP: begin
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(NUM_TIMERS)) begin
          finish  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_ENT_RD: begin
        ent_wb_d = 1'b1;
        state_d  = ST_FINISH;
      end
      ST_FINISH: begin
        finish  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Form the response from the global status after the item
  always_comb begin
    rsp_valid_d          = finish;
    rsp_d                = rsp_q;
    rsp_d.expired        = ent_wb_q && (req_op == OP_CHECK) && ent_exp;
    rsp_d.delay_done     = sys_stat.delay_done;
    rsp_d.run_time       = sys_stat.run_time;
    rsp_d.elapsed        = (req_op == OP_ELAPSED) ? (sys_stat.run_time - req_q.start_time)
                                                  : '0;
    rsp_d.ten_tick_pulse = (req_op == OP_TICK) && sys_stat.pulse;
    if (!finish) begin
      rsp_d = rsp_q;
    end
  end

  // Hold sequencer state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ent_wb_q    <= 1'b0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ent_wb_q    <= ent_wb_d;
      rsp_valid_q <= rsp_valid_d;
      rsp_q       <= rsp_d;
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= cmd_i;
    end
  end

  assign busy        = (state_q != ST_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ===== rtl/mcstb_checker.sv =====
`timescale 1ns / 1ps
module mcstb_checker
  import mcstb_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input mcstb_cmd_t cmd_i,
  input logic       rsp_valid_o,
  input mcstb_rsp_t rsp_o
);

  logic [2:0] last_op_q;

  // Track the op of the item in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_op_q <= OP_TICK;
    end else if (start && !busy) begin
      last_op_q <= cmd_i.op;
    end
  end

  // An accepted item keeps the block busy or answers at once
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || rsp_valid_o))
    else $error("accepted item neither busy nor answered");

  // A response is shown only when the block is idle
  a_rsp_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !busy)
    else $error("response shown while busy");

  // Only a check reports an expiry
  a_expired_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.expired) |-> (last_op_q == OP_CHECK))
    else $error("expired set for an op other than check");

  // Only an elapsed query reports a nonzero elapsed value
  a_elapsed_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && (rsp_o.elapsed != '0)) |-> (last_op_q == OP_ELAPSED))
    else $error("elapsed nonzero for an op other than elapsed query");

  // Only a tick pulses
  a_pulse_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.ten_tick_pulse) |-> (last_op_q == OP_TICK))
    else $error("ten tick pulse for an op other than tick");

endmodule

bind multi_channel_soft_timer_bank_core mcstb_checker u_mcstb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .cmd_i       (cmd_i),
  .rsp_valid_o (rsp_valid_o),
  .rsp_o       (rsp_o)
);
